>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that check their own behavior.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/dsid_pkg.sv
// Types, constants and helper functions for the identifier derivation block.
// No dependencies; the top level, dsid_round, dsid_sha_core and dsid_apb_regs import it.
package dsid_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } work_t;

  typedef enum logic [1:0] {CORE_IDLE, CORE_RUN, CORE_ADD} core_state_t;

  typedef enum logic [2:0] {
    CTL_IDLE, CTL_START0, CTL_WAIT0, CTL_START1, CTL_WAIT1, CTL_DONE
  } ctl_state_t;

  typedef struct packed {
    logic start;
    logic use_iv;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic [1023:0] data;
    logic          two;
  } msg_t;

  localparam logic [2:0] OP_REPLICA_SID = 3'd0;
  localparam logic [2:0] OP_SUB_SID     = 3'd1;
  localparam logic [2:0] OP_LIFT_MSGID  = 3'd2;
  localparam logic [2:0] OP_MSGID       = 3'd3;
  localparam logic [2:0] OP_OP_ID       = 3'd4;
  localparam logic [2:0] OP_FSS_ID      = 3'd5;

  localparam logic [1:0] REG_BASE0 = 2'd0;
  localparam logic [1:0] REG_BASE1 = 2'd1;
  localparam logic [1:0] REG_BASE2 = 2'd2;
  localparam logic [1:0] REG_BASE3 = 2'd3;

  localparam logic [7:0]  STAGE_MAX    = 8'hFF;
  localparam logic [5:0]  LAST_ROUND   = 6'd63;
  localparam logic [31:0] PREFIX_UPPER = 32'h55564343;
  localparam logic [31:0] PREFIX_LOWER = 32'h75766363;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam work_t INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [15:0] bswap16(input logic [15:0] x);
    return {x[7:0], x[15:8]};
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [63:0] bswap64(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[63 - 8*i -: 8] = x[8*i +: 8];
    end
    return r;
  endfunction

  // Builds the padded message, first byte in the top bits. Two-block
  // messages carry their bit length at the very end, one-block messages
  // at the end of the upper half.
  function automatic msg_t build_msg(
    input logic [2:0]        op,
    input logic [3:0][63:0]  base,
    input logic [63:0]       wide,
    input logic [31:0]       wa,
    input logic [31:0]       wb,
    input logic [31:0]       wc,
    input logic [7:0]        ba,
    input logic [7:0]        bb,
    input logic [7:0]        bc,
    input logic [7:0]        bd,
    input logic [15:0]       ha,
    input logic [15:0]       hb,
    input logic [15:0]       hc
  );
    msg_t         m;
    logic [255:0] base_le;
    base_le = {bswap64(base[0]), bswap64(base[1]), bswap64(base[2]), bswap64(base[3])};
    m = '0;
    case (op)
      OP_REPLICA_SID: begin
        m.data[1023 -: 448] = {PREFIX_UPPER, "_SID_REPLICA_V1", base_le, bswap32(wa), 8'h80};
        m.data[575:512] = 64'd440;
      end
      OP_SUB_SID: begin
        m.data[1023 -: 408] = {PREFIX_UPPER, "_SID_SUB_V1", base_le, ha[7:0],
                               bswap16(hb), 8'h80};
        m.data[575:512] = 64'd400;
      end
      OP_LIFT_MSGID: begin
        m.data[1023 -: 528] = {PREFIX_UPPER, "_MSGID_LIFTBATCH_V1", base_le, bswap32(wa),
                               ba, bb, bswap16(ha), bswap16(hb), 8'h80};
        m.data[63:0] = 64'd520;
        m.two = 1'b1;
      end
      OP_MSGID: begin
        m.data[1023 -: 560] = {PREFIX_LOWER, ".msgid.v1", base_le, bswap64(wide),
                               ba, bb, bc, bd, bswap32(wa), bswap32(wb), bswap32(wc),
                               8'h80};
        m.data[63:0] = 64'd552;
        m.two = 1'b1;
      end
      OP_OP_ID: begin
        m.data[1023 -: 432] = {PREFIX_UPPER, "_OPID_V1", base_le, bswap32(wa), ba,
                               bswap16(ha), bswap16(hb), 8'h80};
        m.data[575:512] = 64'd424;
      end
      OP_FSS_ID: begin
        m.data[1023 -: 480] = {PREFIX_UPPER, "_FSSID_V1", base_le, bswap32(wa),
                               bswap16(ha), bswap16(hb), bswap16(hc), bswap32(wb), 8'h80};
        m.data[63:0] = 64'd472;
        m.two = 1'b1;
      end
      default: begin
        m = '0;
      end
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/dsid_if.sv
// Valid/ready channel interfaces for request and digest beats.
// Stand-alone; no package needed.
interface dsid_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [63:0] wide_word;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [7:0]  byte_a;
  logic [7:0]  byte_b;
  logic [7:0]  byte_c;
  logic [7:0]  byte_d;
  logic [15:0] half_a;
  logic [15:0] half_b;
  logic [15:0] half_c;

  modport source (output valid, opcode, wide_word, word_a, word_b, word_c, byte_a,
                  byte_b, byte_c, byte_d, half_a, half_b, half_c, input ready);
  modport sink (input valid, opcode, wide_word, word_a, word_b, word_c, byte_a,
                byte_b, byte_c, byte_d, half_a, half_b, half_c, output ready);
endinterface

interface dsid_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word0;
  logic [63:0] digest_word1;
  logic [63:0] digest_word2;
  logic [63:0] digest_word3;
  logic        stage_error;

  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  stage_error, input ready);
  modport sink (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                stage_error, output ready);
endinterface

>>> rtl/core/sha256_domain_separated_id_derive_top.sv
// Top level of the domain-separated identifier derivation block.
// Depends on dsid_pkg, dsid_if, dsid_apb_regs, dsid_sha_core and assert_macros.svh.
//
// Usage: a request beat on req carries an opcode and its fields. The block
// builds the tagged preimage (domain tag, 32-byte base identifier from the
// APB registers, fields in little-endian order), pads it, and runs SHA-256
// over one or two 64-byte blocks. One digest beat per request leaves on rsp,
// as four little-endian 64-bit words plus the stage_error flag.
// Each block goes through a load step, 64 rounds and a chaining add. The
// sequencer returns to idle on the edge that raises rsp.valid, so the next
// request can be accepted while the digest is still held on rsp.
// A sub identifier with a stage above 255, or an unused opcode, skips the
// hash and goes straight from idle to the done state with an all-zero digest.
// One request is in flight at a time; req.ready is high only while idle.
// The digest sits in an output register; if the receiver stalls, the block
// finishes the next request and holds it until the register frees up.
// Reset (rst, synchronous) clears the sequencer, the output valid and the
// base identifier registers. Base identifier writes belong in idle periods.
`include "assert_macros.svh"
module sha256_domain_separated_id_derive_top
  import dsid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dsid_in_if.sink     req,
  dsid_out_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  ctl_state_t       state;
  ctl_state_t       state_next;
  logic [3:0][63:0] base_id;
  msg_t             msg_in;
  logic [1023:0]    msg;
  logic             two;
  logic             zero;
  logic             err;
  logic             err_in;
  logic             zero_in;
  logic             accept;
  logic             out_free;
  core_ctl_t        core_ctl;
  core_stat_t       core_stat;
  logic [511:0]     block;
  logic [255:0]     hash;

  dsid_apb_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .base_id(base_id)
  );

  dsid_sha_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctl  (core_ctl),
    .block(block),
    .stat (core_stat),
    .hash (hash)
  );

  // The padded message is fixed at accept; the second block follows the first.
  assign msg_in = build_msg(req.opcode, base_id, req.wide_word, req.word_a, req.word_b,
                            req.word_c, req.byte_a, req.byte_b, req.byte_c, req.byte_d,
                            req.half_a, req.half_b, req.half_c);
  assign err_in  = (req.opcode == OP_SUB_SID) && (req.half_a > {8'd0, STAGE_MAX});
  assign zero_in = err_in || (req.opcode > OP_FSS_ID);
  assign accept  = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign block   = (state == CTL_START1) ? msg[511:0] : msg[1023:512];

  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE:   if (accept) state_next = zero_in ? CTL_DONE : CTL_START0;
      CTL_START0: state_next = CTL_WAIT0;
      CTL_WAIT0:  if (core_stat.done) state_next = two ? CTL_START1 : CTL_DONE;
      CTL_START1: state_next = CTL_WAIT1;
      CTL_WAIT1:  if (core_stat.done) state_next = CTL_DONE;
      CTL_DONE:   if (out_free) state_next = CTL_IDLE;
      default:    state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    req.ready       = 1'b0;
    core_ctl.start  = 1'b0;
    core_ctl.use_iv = 1'b0;
    case (state)
      CTL_IDLE:   req.ready = 1'b1;
      CTL_START0: begin
        core_ctl.start  = 1'b1;
        core_ctl.use_iv = 1'b1;
      end
      CTL_START1: core_ctl.start = 1'b1;
      default:    req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTL_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == CTL_DONE && out_free) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msg  <= msg_in.data;
      two  <= msg_in.two;
      zero <= zero_in;
      err  <= err_in;
    end
    if (state == CTL_DONE && out_free) begin
      rsp.digest_word0 <= zero ? 64'd0 : bswap64(hash[255:192]);
      rsp.digest_word1 <= zero ? 64'd0 : bswap64(hash[191:128]);
      rsp.digest_word2 <= zero ? 64'd0 : bswap64(hash[127:64]);
      rsp.digest_word3 <= zero ? 64'd0 : bswap64(hash[63:0]);
      rsp.stage_error  <= err;
    end
  end

  // An accepted request must drop ready until its digest is handed off.
  `ASSERT_NEXT(a_busy_after_accept, accept, !req.ready)
  // The compressor reports completion only while the sequencer waits for it.
  `ASSERT_IMP(a_done_in_wait, core_stat.done, (state == CTL_WAIT0) || (state == CTL_WAIT1))
  // A new block is never started on a busy compressor.
  `ASSERT_IMP(a_start_when_idle, core_ctl.start, !core_stat.busy)
  // A stage error always comes with an all-zero digest; words 0 and 3 are checked.
  `ASSERT_IMP(a_error_zero, rsp.valid && rsp.stage_error,
              (rsp.digest_word0 == 64'd0) && (rsp.digest_word3 == 64'd0))
endmodule

>>> rtl/core/dsid_round.sv
// One SHA-256 compression round on the eight working variables.
// Depends on dsid_pkg for the sigma functions and the work_t type.
module dsid_round
  import dsid_pkg::*;
(
  input  work_t work_in,
  input  word_t k,
  input  word_t w,
  output work_t work_out
);
  word_t t1;
  word_t t2;

  always_comb begin
    t1 = work_in.h + big_sigma1(work_in.e) +
         ((work_in.e & work_in.f) ^ (~work_in.e & work_in.g)) + k + w;
    t2 = big_sigma0(work_in.a) +
         ((work_in.a & work_in.b) ^ (work_in.a & work_in.c) ^ (work_in.b & work_in.c));
    work_out.a = t1 + t2;
    work_out.b = work_in.a;
    work_out.c = work_in.b;
    work_out.d = work_in.c;
    work_out.e = work_in.d + t1;
    work_out.f = work_in.e;
    work_out.g = work_in.f;
    work_out.h = work_in.g;
  end
endmodule

>>> rtl/core/dsid_sha_core.sv
// Iterative SHA-256 block compressor: one round per cycle, 16-word schedule window.
// Depends on dsid_pkg and dsid_round.
module dsid_sha_core
  import dsid_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  core_ctl_t    ctl,
  input  logic [511:0] block,
  output core_stat_t   stat,
  output logic [255:0] hash
);
  core_state_t state;
  core_state_t state_next;
  work_t       work;
  work_t       work_rnd;
  work_t       chain;
  work_t       seed;
  word_t       win [16];
  word_t       w_new;
  logic [5:0]  rnd;

  dsid_round u_round (
    .work_in (work),
    .k       (ROUND_K[rnd]),
    .w       (win[0]),
    .work_out(work_rnd)
  );

  assign seed  = ctl.use_iv ? INIT_H : chain;
  assign w_new = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  assign hash  = chain;

  always_comb begin
    state_next = state;
    case (state)
      CORE_IDLE: if (ctl.start) state_next = CORE_RUN;
      CORE_RUN:  if (rnd == LAST_ROUND) state_next = CORE_ADD;
      CORE_ADD:  state_next = CORE_IDLE;
      default:   state_next = CORE_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = 1'b0;
    stat.done = 1'b0;
    case (state)
      CORE_IDLE: stat.busy = 1'b0;
      CORE_RUN:  stat.busy = 1'b1;
      CORE_ADD: begin
        stat.busy = 1'b1;
        stat.done = 1'b1;
      end
      default:   stat.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (state == CORE_RUN) rnd <= rnd + 6'd1;
      else rnd <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == CORE_IDLE && ctl.start) begin
      chain <= seed;
      work  <= seed;
      for (int i = 0; i < 16; i++) begin
        win[i] <= block[511 - 32*i -: 32];
      end
    end else if (state == CORE_RUN) begin
      work <= work_rnd;
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_new;
    end else if (state == CORE_ADD) begin
      chain.a <= chain.a + work.a;
      chain.b <= chain.b + work.b;
      chain.c <= chain.c + work.c;
      chain.d <= chain.d + work.d;
      chain.e <= chain.e + work.e;
      chain.f <= chain.f + work.f;
      chain.g <= chain.g + work.g;
      chain.h <= chain.h + work.h;
    end
  end
endmodule

>>> rtl/core/dsid_apb_regs.sv
// APB register file holding the 32-byte base identifier as four 64-bit words.
// Depends on dsid_pkg for the register index names.
module dsid_apb_regs
  import dsid_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output logic [3:0][63:0] base_id
);
  logic [1:0] idx;

  assign idx    = paddr[4:3];
  assign pready = 1'b1;

  always_comb begin
    case (idx)
      REG_BASE0: prdata = base_id[0];
      REG_BASE1: prdata = base_id[1];
      REG_BASE2: prdata = base_id[2];
      REG_BASE3: prdata = base_id[3];
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id <= '0;
    end else if (psel && penable && pwrite && pready) begin
      base_id[idx] <= pwdata;
    end
  end
endmodule
